### rtl/core/catf_pkg.sv
// Package for the text stream line number and escape filter.
// Holds byte codes, register indexes and the run descriptor type shared by
// the decode stage and the byte emitter. Depends on nothing.
`default_nettype none

package catf_pkg;

    // Configuration port widths.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SHOW_NONPRINTING = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOW_ENDS        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOW_TABS        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_MODE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SQUEEZE_BLANK    = 3'd4;

    // Line numbering modes.
    localparam logic [1:0] NUM_NONE     = 2'd0;
    localparam logic [1:0] NUM_ALL      = 2'd1;
    localparam logic [1:0] NUM_NONBLANK = 2'd2;

    // Byte codes.
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_UPPER_I = 8'h49;
    localparam logic [7:0] CH_UPPER_M = 8'h4D;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CH_CTRL_END = 8'h20;
    localparam logic [3:0] CH_DIGIT_HI = 4'h3;

    // Escape part of one run: up to four bytes, esc[0] goes out first.
    typedef struct packed {
        logic            num_en;
        logic [1:0]      esc_last;
        logic [3:0][7:0] esc;
    } plan_t;

endpackage

`default_nettype wire

### rtl/core/catf_decode.sv
// Decode stage of the text stream filter: configuration registers, line
// state (newline flag, blank run, BCD line number) and the run descriptor
// for each accepted byte. Depends on catf_pkg.
`default_nettype none

module catf_decode #(
    parameter int NUMBER_DIGITS = 6
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [catf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [catf_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    input  wire logic                              in_fire,
    input  wire logic [7:0]                        in_byte,
    output logic                                   plan_load,
    output catf_pkg::plan_t                        plan,
    output logic [4*NUMBER_DIGITS-1:0]             plan_number
);
    import catf_pkg::*;

    localparam int NW = 4 * NUMBER_DIGITS;

    logic          show_np_reg;
    logic          show_ends_reg;
    logic          show_tabs_reg;
    logic [1:0]    number_mode_reg;
    logic          squeeze_reg;
    logic          prev_nl_reg;
    logic [1:0]    blank_run_reg;
    logic [1:0]    blank_run_next;
    logic [NW-1:0] number_reg;
    logic [NW-1:0] number_next;

    logic          is_nl;
    logic          is_tab;
    logic          squeezed;
    logic          num_en;
    logic          all_nines;
    logic          carry;
    logic [7:0]    low7;
    logic [7:0]    core0;
    logic [7:0]    core1;
    logic          core_last;

    assign is_nl  = (in_byte == CH_NL);
    assign is_tab = (in_byte == CH_TAB);
    assign low7   = {1'b0, in_byte[6:0]};

    // Blank run counts newlines that follow a newline while squeezing is on, saturating at two.
    always_comb begin
        blank_run_next = 2'd0;
        if (squeeze_reg && prev_nl_reg && is_nl) begin
            blank_run_next = (blank_run_reg == 2'd2) ? 2'd2 : blank_run_reg + 2'd1;
        end
    end

    assign squeezed = (blank_run_next == 2'd2);
    assign num_en   = !squeezed && prev_nl_reg &&
                      ((number_mode_reg == NUM_ALL) ||
                       ((number_mode_reg == NUM_NONBLANK) && !is_nl));

    // BCD increment with saturation at all nines.
    always_comb begin
        number_next = number_reg;
        all_nines   = 1'b1;
        carry       = 1'b1;
        for (int i = 0; i < NUMBER_DIGITS; i++) begin
            if (number_reg[4*i +: 4] != 4'd9) begin
                all_nines = 1'b0;
            end
        end
        if (!all_nines) begin
            for (int i = 0; i < NUMBER_DIGITS; i++) begin
                if (carry) begin
                    if (number_reg[4*i +: 4] >= 4'd9) begin
                        number_next[4*i +: 4] = 4'd0;
                    end else begin
                        number_next[4*i +: 4] = number_reg[4*i +: 4] + 4'd1;
                        carry = 1'b0;
                    end
                end
            end
        end
    end

    // Caret form of the low seven bits.
    always_comb begin
        core0     = low7;
        core1     = CH_QMARK;
        core_last = 1'b0;
        if (low7 < CH_CTRL_END) begin
            core0     = CH_CARET;
            core1     = {3'b010, low7[4:0]};
            core_last = 1'b1;
        end else if (low7 == CH_DEL) begin
            core0     = CH_CARET;
            core1     = CH_QMARK;
            core_last = 1'b1;
        end
    end

    // Escape bytes of the run, in output order.
    always_comb begin
        plan          = '0;
        plan.num_en   = num_en;
        if (is_nl) begin
            if (show_ends_reg) begin
                plan.esc[0]   = CH_DOLLAR;
                plan.esc[1]   = CH_NL;
                plan.esc_last = 2'd1;
            end else begin
                plan.esc[0]   = CH_NL;
            end
        end else if (is_tab) begin
            if (show_tabs_reg) begin
                plan.esc[0]   = CH_CARET;
                plan.esc[1]   = CH_UPPER_I;
                plan.esc_last = 2'd1;
            end else begin
                plan.esc[0]   = CH_TAB;
            end
        end else if (show_np_reg) begin
            if (in_byte[7]) begin
                plan.esc[0]   = CH_UPPER_M;
                plan.esc[1]   = CH_DASH;
                plan.esc[2]   = core0;
                plan.esc[3]   = core1;
                plan.esc_last = {1'b1, core_last};
            end else begin
                plan.esc[0]   = core0;
                plan.esc[1]   = core1;
                plan.esc_last = {1'b0, core_last};
            end
        end else begin
            plan.esc[0] = in_byte;
        end
    end

    assign plan_load   = in_fire && !squeezed;
    assign plan_number = number_reg;

    // Configuration writes and line state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            show_np_reg     <= 1'b0;
            show_ends_reg   <= 1'b0;
            show_tabs_reg   <= 1'b0;
            number_mode_reg <= NUM_NONE;
            squeeze_reg     <= 1'b0;
            prev_nl_reg     <= 1'b1;
            blank_run_reg   <= 2'd0;
            number_reg      <= NW'(1);
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_SHOW_NONPRINTING: show_np_reg     <= cfg_wr_data[0];
                    CFG_SHOW_ENDS:        show_ends_reg   <= cfg_wr_data[0];
                    CFG_SHOW_TABS:        show_tabs_reg   <= cfg_wr_data[0];
                    CFG_NUMBER_MODE:      number_mode_reg <= cfg_wr_data[1:0];
                    CFG_SQUEEZE_BLANK:    squeeze_reg     <= cfg_wr_data[0];
                    default: ;
                endcase
            end
            if (in_fire) begin
                prev_nl_reg   <= is_nl;
                blank_run_reg <= blank_run_next;
                if (num_en) begin
                    number_reg <= number_next;
                end
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/catf_emit.sv
// Byte emitter of the text stream filter: holds one run descriptor and
// sends its bytes, one per cycle while the receiver is ready, through the
// output register. Depends on catf_pkg.
`default_nettype none

module catf_emit #(
    parameter int NUMBER_DIGITS = 6
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          plan_load,
    input  wire catf_pkg::plan_t               plan,
    input  wire logic [4*NUMBER_DIGITS-1:0]    plan_number,
    output logic                               slot_free,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [7:0]                         m_tdata,
    output logic                               m_tlast
);
    import catf_pkg::*;

    localparam int NW    = 4 * NUMBER_DIGITS;
    localparam int POS_W = $clog2(NUMBER_DIGITS + 1);
    localparam logic [POS_W-1:0] TAB_POS    = POS_W'(NUMBER_DIGITS);
    localparam logic [POS_W-1:0] LAST_DIGIT = POS_W'(NUMBER_DIGITS - 1);

    logic             plan_valid_reg;
    logic             num_en_reg;
    logic [1:0]       esc_last_reg;
    logic [3:0][7:0]  esc_reg;
    logic [NW-1:0]    num_reg;
    logic [POS_W-1:0] pos_reg;
    logic             seen_reg;
    logic [1:0]       esc_idx_reg;
    logic             m_tvalid_reg;
    logic [7:0]       m_tdata_reg;
    logic             m_tlast_reg;

    logic             out_free;
    logic             emit;
    logic             done;
    logic [3:0]       digit;
    logic [7:0]       cur_byte;
    logic             cur_last;

    assign out_free = !m_tvalid_reg || m_tready;
    assign emit     = plan_valid_reg && out_free;
    assign digit    = num_reg[NW-1 -: 4];

    // Current byte: number digits and tab first, then the escape bytes.
    always_comb begin
        cur_last = 1'b0;
        if (num_en_reg) begin
            if (pos_reg == TAB_POS) begin
                cur_byte = CH_TAB;
            end else if (digit == 4'd0 && !seen_reg && pos_reg != LAST_DIGIT) begin
                cur_byte = CH_SPACE;
            end else begin
                cur_byte = {CH_DIGIT_HI, digit};
            end
        end else begin
            cur_byte = esc_reg[esc_idx_reg];
            cur_last = (esc_idx_reg == esc_last_reg);
        end
    end

    assign done      = emit && cur_last;
    assign slot_free = !plan_valid_reg || done;

    // Control: descriptor occupancy and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plan_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (plan_load) begin
                plan_valid_reg <= 1'b1;
            end else if (done) begin
                plan_valid_reg <= 1'b0;
            end
            if (emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload: descriptor contents, step position and output byte.
    always_ff @(posedge aclk) begin
        if (plan_load) begin
            num_en_reg   <= plan.num_en;
            esc_last_reg <= plan.esc_last;
            esc_reg      <= plan.esc;
            num_reg      <= plan_number;
            pos_reg      <= '0;
            seen_reg     <= 1'b0;
            esc_idx_reg  <= 2'd0;
        end else if (emit) begin
            if (num_en_reg) begin
                if (pos_reg == TAB_POS) begin
                    num_en_reg <= 1'b0;
                end else begin
                    pos_reg  <= pos_reg + POS_W'(1);
                    num_reg  <= num_reg << 4;
                    seen_reg <= seen_reg || (digit != 4'd0);
                end
            end else begin
                esc_idx_reg <= esc_idx_reg + 2'd1;
            end
        end
        if (emit) begin
            m_tdata_reg <= cur_byte;
            m_tlast_reg <= cur_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

### rtl/core/text_stream_line_number_escape_filter_unit.sv
// Top level of the text stream filter: line numbering, blank-line squeezing
// and display of line ends, tabs and non-printing bytes.
// Depends on catf_pkg, catf_decode and catf_emit.
//
// Usage:
//   The s_ channel takes one raw text byte per transfer in s_tdata. The m_
//   channel gives the output bytes in m_tdata; m_tlast marks the last byte
//   caused by one input byte. A squeezed blank line gives no output bytes.
//   Registers are written through cfg_wr_en / cfg_index / cfg_wr_data while
//   the stream is idle: 0 show_nonprinting, 1 show_ends, 2 show_tabs,
//   3 number_mode, 4 squeeze_blank.
//   An input byte's first output byte passes the descriptor register, then the
//   output register. The emitter sends one byte per cycle while the receiver
//   is ready; an input byte expands to 1 to 4 bytes of escape, plus
//   NUMBER_DIGITS + 1 when its line is numbered. Single-byte runs go at one
//   input byte per cycle while the receiver is ready; the next input byte is
//   taken in the cycle the last byte of the current run moves to the output
//   register. Reset clears the configuration and control registers, puts the
//   stream at the start of a line with line number 1 and empties both stages.
//   When the receiver stalls, the output register holds its byte and one run
//   waits behind it; after that s_tready goes low.
`default_nettype none

module text_stream_line_number_escape_filter_unit #(
    parameter int NUMBER_DIGITS = 6
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Configuration write port.
    input  wire logic                              cfg_wr_en,
    input  wire logic [catf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [catf_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    // Input stream.
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [7:0]                        s_tdata,   // [7:0] in_byte
    // Output stream.
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [7:0]                             m_tdata,   // [7:0] out_byte
    output logic                                   m_tlast    // last_of_run
);
    import catf_pkg::*;

    logic                         in_fire;
    logic                         plan_load;
    plan_t                        plan;
    logic [4*NUMBER_DIGITS-1:0]   plan_number;
    logic                         slot_free;

    assign s_tready = slot_free;
    assign in_fire  = s_tvalid && slot_free;

    // Line state and run decode.
    catf_decode #(
        .NUMBER_DIGITS(NUMBER_DIGITS)
    ) u_decode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .in_fire     (in_fire),
        .in_byte     (s_tdata),
        .plan_load   (plan_load),
        .plan        (plan),
        .plan_number (plan_number)
    );

    // One output byte per cycle while the receiver is ready.
    catf_emit #(
        .NUMBER_DIGITS(NUMBER_DIGITS)
    ) u_emit (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .plan_load   (plan_load),
        .plan        (plan),
        .plan_number (plan_number),
        .slot_free   (slot_free),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

`default_nettype wire

### rtl/core/catf_checker.sv
// Port checker for the text stream filter, bound to the top level.
// Watches the stream ports only. Depends on the top level's port list.
`default_nettype none

module catf_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast
);

    // A stalled output transfer keeps its byte and marker.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output changed while stalled");

    // Reset empties the output register.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // Reset leaves the block ready for input.
    assert property (@(posedge aclk) !aresetn |=> s_tready)
        else $error("input not ready after reset");

    // A run continues without gaps until its last byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("gap inside an output run");

endmodule

bind text_stream_line_number_escape_filter_unit catf_checker u_catf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

### sim/tb_text_stream_line_number_escape_filter_unit.sv
// Self-checking testbench for the text stream line number and escape filter.
// Predicts every output byte from each accepted input byte and checks the m_ stream.
// Depends on catf_pkg and text_stream_line_number_escape_filter_unit.
`default_nettype none

module tb_text_stream_line_number_escape_filter_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import catf_pkg::*;

    localparam int NUM_DIGITS   = 6;
    // Cycles of nothing moving before the run is declared hung.
    localparam int STALL_LIMIT  = 2000;
    // Settling time after the last expected byte: one full numbered run and margin.
    localparam int SETTLE_CYCLES = NUM_DIGITS + 10;
    // Length of the long receiver hold-off.
    localparam int HOLD_CYCLES  = 80;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } out_byte_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [7:0]            m_tdata;
    logic                  m_tlast;

    // Predicted output bytes, oldest first.
    out_byte_t expected_out[$];

    // Filter settings and line state as the predictor sees them.
    logic                      shows_nonprint;
    logic                      shows_ends;
    logic                      shows_tabs;
    logic [1:0]                numbering;
    logic                      squeezes;
    logic                      at_line_start;
    logic [1:0]                blank_lines;
    logic [4*NUM_DIGITS-1:0]   line_bcd;

    int error_count = 0;
    int bytes_in = 0;
    int bytes_out = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_requests = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    text_stream_line_number_escape_filter_unit #(
        .NUMBER_DIGITS(NUM_DIGITS)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),   // [7:0] in_byte
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),   // [7:0] out_byte
        .m_tlast     (m_tlast)    // last_of_run
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Work out the bytes one input byte turns into and queue them.
    task automatic predict_filter_output(input logic [7:0] c);
        logic [7:0] run[$];
        logic [7:0] low;
        logic       is_nl;
        logic       was_start;
        logic       all_nines;
        logic       carry;
        int         top;
        int         pos;
        is_nl = (c == CH_NL);
        was_start = at_line_start;

        // Blank-line run tracking; held at zero while squeezing is off.
        if (squeezes && was_start && is_nl) begin
            if (blank_lines < 2'd2) begin
                blank_lines = blank_lines + 2'd1;
            end
        end else begin
            blank_lines = 2'd0;
        end
        at_line_start = is_nl;
        if (blank_lines >= 2'd2) begin
            return;
        end

        // Line number: right-aligned digits, then a tab; saturates at all nines.
        if (was_start && (numbering == NUM_ALL || (numbering == NUM_NONBLANK && !is_nl))) begin
            top = 0;
            for (pos = 0; pos < NUM_DIGITS; pos++) begin
                if (line_bcd[4*pos +: 4] != 4'd0) begin
                    top = pos;
                end
            end
            for (pos = NUM_DIGITS - 1; pos >= 0; pos--) begin
                run.push_back(pos > top ? CH_SPACE : {CH_DIGIT_HI, line_bcd[4*pos +: 4]});
            end
            run.push_back(CH_TAB);
            all_nines = 1'b1;
            for (pos = 0; pos < NUM_DIGITS; pos++) begin
                if (line_bcd[4*pos +: 4] != 4'd9) begin
                    all_nines = 1'b0;
                end
            end
            if (!all_nines) begin
                carry = 1'b1;
                for (pos = 0; pos < NUM_DIGITS; pos++) begin
                    if (carry) begin
                        if (line_bcd[4*pos +: 4] == 4'd9) begin
                            line_bcd[4*pos +: 4] = 4'd0;
                        end else begin
                            line_bcd[4*pos +: 4] = line_bcd[4*pos +: 4] + 4'd1;
                            carry = 1'b0;
                        end
                    end
                end
            end
        end

        // The byte itself, escaped as the settings ask.
        if (is_nl) begin
            if (shows_ends) begin
                run.push_back(CH_DOLLAR);
            end
            run.push_back(CH_NL);
        end else if (c == CH_TAB) begin
            if (shows_tabs) begin
                run.push_back(CH_CARET);
                run.push_back(CH_UPPER_I);
            end else begin
                run.push_back(CH_TAB);
            end
        end else if (shows_nonprint) begin
            low = {1'b0, c[6:0]};
            if (c[7]) begin
                run.push_back(CH_UPPER_M);
                run.push_back(CH_DASH);
            end
            if (low < CH_CTRL_END) begin
                run.push_back(CH_CARET);
                run.push_back(low + 8'd64);
            end else if (low == CH_DEL) begin
                run.push_back(CH_CARET);
                run.push_back(CH_QMARK);
            end else begin
                run.push_back(low);
            end
        end else begin
            run.push_back(c);
        end

        for (pos = 0; pos < run.size(); pos++) begin
            expected_out.push_back('{ch: run[pos], last: (pos == run.size() - 1)});
        end
    endtask

    // Write one register at the falling edge and mirror it in the predictor.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_SHOW_NONPRINTING: shows_nonprint = val[0];
            CFG_SHOW_ENDS:        shows_ends = val[0];
            CFG_SHOW_TABS:        shows_tabs = val[0];
            CFG_NUMBER_MODE:      numbering = val[1:0];
            CFG_SQUEEZE_BLANK:    squeezes = val[0];
            default: ;
        endcase
    endtask

    task automatic cfg_write_all(input logic [CFG_DATA_W-1:0] nonprint, input logic [CFG_DATA_W-1:0] ends,
                                 input logic [CFG_DATA_W-1:0] tabs, input logic [CFG_DATA_W-1:0] mode,
                                 input logic [CFG_DATA_W-1:0] squeeze);
        cfg_write(CFG_SHOW_NONPRINTING, nonprint);
        cfg_write(CFG_SHOW_ENDS, ends);
        cfg_write(CFG_SHOW_TABS, tabs);
        cfg_write(CFG_NUMBER_MODE, mode);
        cfg_write(CFG_SQUEEZE_BLANK, squeeze);
    endtask

    // Offer one byte, with an optional gap before it, and hold it until the transfer.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            gap = $urandom_range(1, 5);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do @(posedge aclk); while (!s_tready);
        predict_filter_output(b);
        bytes_in++;
    endtask

    // Stop offering and wait until every predicted byte has arrived and the block is quiet.
    task automatic drain_stream();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_out.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Text-like lines with random content, runs of newlines, and some raw noise.
    task automatic send_random_text(input int count);
        int         sent;
        int         len;
        int         k;
        logic [7:0] b;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(99) < 75) begin
                len = $urandom_range(0, 6);
                for (k = 0; k < len; k++) begin
                    case ($urandom_range(9))
                        0: b = CH_TAB;
                        1: b = 8'($urandom_range(0, 255));
                        default: b = 8'($urandom_range(8'h20, 8'h7E));
                    endcase
                    send_byte(b);
                    sent++;
                end
                repeat ($urandom_range(1, 3)) begin
                    send_byte(CH_NL);
                    sent++;
                end
            end else begin
                send_byte(8'($urandom_range(0, 255)));
                sent++;
            end
        end
    endtask

    // Reset settings: bytes pass through untouched, extremes included.
    task automatic test_plain_passthrough();
        send_byte(8'h41);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_TAB);
        send_byte(CH_NL);
        drain_stream();
    endtask

    // Caret and M- notation, shown ends and tabs; the wide write checks that
    // only the low bit of a one-bit register counts.
    task automatic test_escapes();
        cfg_write_all(2'd3, 2'd1, 2'd1, NUM_NONE, 2'd0);
        send_byte(8'h00);
        send_byte(8'h1F);
        send_byte(CH_DEL);
        send_byte(8'h80);
        send_byte(8'hFF);
        send_byte(8'hA0);
        send_byte(CH_SPACE);
        send_byte(CH_TAB);
        send_byte(CH_NL);
        drain_stream();
    endtask

    // Every line numbered while a run of blank lines is squeezed.
    task automatic test_number_and_squeeze();
        cfg_write_all(2'd0, 2'd0, 2'd0, NUM_ALL, 2'd1);
        send_byte(CH_NL);
        send_byte(CH_NL);
        send_byte(CH_NL);
        send_byte(8'h71);
        send_byte(CH_NL);
        drain_stream();
    endtask

    // Only non-blank lines numbered, squeeze off again.
    task automatic test_nonblank_numbering();
        cfg_write(CFG_NUMBER_MODE, NUM_NONBLANK);
        cfg_write(CFG_SQUEEZE_BLANK, 2'd0);
        send_byte(CH_NL);
        send_byte(8'h62);
        send_byte(CH_NL);
        drain_stream();
    endtask

    // The unused numbering mode numbers nothing; writes past the last register change nothing.
    task automatic test_unused_mode_and_index();
        int idx;
        cfg_write(CFG_NUMBER_MODE, 2'd3);
        for (idx = CFG_SQUEEZE_BLANK + 1; idx < (1 << CFG_IDX_W); idx++) begin
            cfg_write(CFG_IDX_W'(idx), 2'd3);
        end
        send_byte(8'h7A);
        send_byte(CH_NL);
        drain_stream();
    endtask

    // Long receiver hold-off while the sender keeps offering, then a full pause.
    task automatic test_back_pressure();
        cfg_write_all(2'd1, 2'd1, 2'd1, NUM_ALL, 2'd1);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_requests++;
        send_random_text(12);
        drain_stream();
        send_random_text(8);
        drain_stream();
    endtask

    // Random settings and traffic under each idling pattern.
    task automatic test_random_traffic();
        int phase;
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            cfg_write_all(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                          2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                          2'($urandom_range(0, 3)));
            send_random_text(18);
            drain_stream();
        end
    endtask

    // Receiver: a long hold-off when one is requested, otherwise random stalls.
    always @(negedge aclk) begin
        if (hold_seen != hold_requests) begin
            hold_seen <= hold_requests;
            m_tready <= 1'b0;
            hold_left <= HOLD_CYCLES - 1;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each output transfer with the oldest predicted byte.
    always @(posedge aclk) begin
        out_byte_t want;
        if (aresetn && m_tvalid && m_tready) begin
            bytes_out++;
            if (expected_out.size() == 0) begin
                $display("%0t: unexpected output byte %02h last %0b, nothing expected",
                         $time, m_tdata, m_tlast);
                error_count++;
            end else begin
                want = expected_out.pop_front();
                if (want.ch !== m_tdata || want.last !== m_tlast) begin
                    $display("%0t: output mismatch: expected %02h last %0b, got %02h last %0b",
                             $time, want.ch, want.last, m_tdata, m_tlast);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles in which no transfer happens on either side.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        shows_nonprint = 1'b0;
        shows_ends = 1'b0;
        shows_tabs = 1'b0;
        numbering = NUM_NONE;
        squeezes = 1'b0;
        at_line_start = 1'b1;
        blank_lines = 2'd0;
        line_bcd = (4*NUM_DIGITS)'(1);

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_plain_passthrough();
        test_escapes();
        test_number_and_squeeze();
        test_nonblank_numbering();
        test_unused_mode_and_index();
        test_back_pressure();
        test_random_traffic();

        $display("covered %0d input bytes and %0d output bytes across plain, escaped,",
                 bytes_in, bytes_out);
        $display("numbered and squeezed settings with sender gaps and receiver stalls");
        if (error_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire

### text_stream_line_number_escape_filter_unit.f
rtl/core/catf_pkg.sv
rtl/core/catf_decode.sv
rtl/core/catf_emit.sv
rtl/core/text_stream_line_number_escape_filter_unit.sv
rtl/core/catf_checker.sv
sim/tb_text_stream_line_number_escape_filter_unit.sv
